>>> design/rifs_pkg.sv
`default_nettype none

package rifs_pkg;

	// Default widths of the section.
	localparam int DEF_SAMPLE_WIDTH     = 16;
	localparam int DEF_COEF_WIDTH       = 24;
	localparam int DEF_HISTORY_HEADROOM = 4;

	// Integer bits of a coefficient (Q3.20 keeps sign plus three).
	localparam int COEF_INT_BITS = 4;

	// Tap counts: current input plus two input taps and four output taps.
	localparam int NUM_X_TAPS = 2;
	localparam int NUM_Y_TAPS = 4;
	localparam int NUM_COEF   = 1 + NUM_X_TAPS + NUM_Y_TAPS;

	// Configuration register map.
	localparam int CFG_INDEX_WIDTH = 3;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_COEF_A0      = 3'd0,
		REG_COEF_A1      = 3'd1,
		REG_COEF_A2      = 3'd2,
		REG_COEF_B1      = 3'd3,
		REG_COEF_B2      = 3'd4,
		REG_COEF_B3      = 3'd5,
		REG_COEF_B4      = 3'd6,
		REG_OUTPUT_HALVE = 3'd7
	} cfg_reg_t;

endpackage

`default_nettype wire

>>> design/rifs_mac.sv
`default_nettype none

module rifs_mac
	import rifs_pkg::*;
#(
	parameter int SAMPLE_WIDTH     = DEF_SAMPLE_WIDTH,
	parameter int COEF_WIDTH       = DEF_COEF_WIDTH,
	parameter int HISTORY_HEADROOM = DEF_HISTORY_HEADROOM
) (
	input  wire logic signed [COEF_WIDTH-1:0]                     coef   [NUM_COEF],
	input  wire logic                                             halve,
	input  wire logic signed [SAMPLE_WIDTH-1:0]                   x,
	input  wire logic signed [SAMPLE_WIDTH-1:0]                   x_hist [NUM_X_TAPS],
	input  wire logic signed [SAMPLE_WIDTH+HISTORY_HEADROOM-1:0]  y_hist [NUM_Y_TAPS],
	output logic signed [SAMPLE_WIDTH+HISTORY_HEADROOM-1:0]       y_new,
	output logic signed [SAMPLE_WIDTH-1:0]                        sample
);

	localparam int HW     = SAMPLE_WIDTH + HISTORY_HEADROOM;
	localparam int CF     = COEF_WIDTH - COEF_INT_BITS;
	localparam int PROD_W = COEF_WIDTH + HW;
	localparam int ACC_W  = PROD_W + $clog2(NUM_COEF);

	logic signed [HW-1:0]     tap  [NUM_COEF];
	logic signed [PROD_W-1:0] prod [NUM_COEF];
	logic signed [ACC_W-1:0]  acc;
	logic signed [ACC_W-1:0]  acc_rnd;
	logic signed [ACC_W-1:0]  acc_sh;
	logic signed [HW-1:0]     halved;

	// Line up the taps with their coefficients: x, x1, x2, y1..y4.
	always_comb begin
		tap[0] = HW'(x);
		for (int i = 0; i < NUM_X_TAPS; i++) begin
			tap[1+i] = HW'(x_hist[i]);
		end
		for (int i = 0; i < NUM_Y_TAPS; i++) begin
			tap[1+NUM_X_TAPS+i] = y_hist[i];
		end
	end

	// Parallel multipliers feeding one sum.
	always_comb begin
		acc = '0;
		for (int i = 0; i < NUM_COEF; i++) begin
			prod[i] = coef[i] * tap[i];
			acc     = acc + ACC_W'(prod[i]);
		end
	end

	// Round to nearest with ties upward, then drop the fraction bits.
	assign acc_rnd = acc + (ACC_W'(1) << (CF - 1));
	assign acc_sh  = acc_rnd >>> CF;

	// Clamp to the history width.
	always_comb begin
		if (acc_sh[ACC_W-1:HW-1] == {(ACC_W-HW+1){acc_sh[ACC_W-1]}}) begin
			y_new = acc_sh[HW-1:0];
		end else begin
			y_new = {acc_sh[ACC_W-1], {(HW-1){~acc_sh[ACC_W-1]}}};
		end
	end

	// Optional halving, then clamp to the sample width.
	assign halved = halve ? (y_new >>> 1) : y_new;

	always_comb begin
		if (halved[HW-1:SAMPLE_WIDTH-1] == {(HW-SAMPLE_WIDTH+1){halved[HW-1]}}) begin
			sample = halved[SAMPLE_WIDTH-1:0];
		end else begin
			sample = {halved[HW-1], {(SAMPLE_WIDTH-1){~halved[HW-1]}}};
		end
	end

endmodule

`default_nettype wire

>>> design/recursive_iir_filter_section_top.sv
`default_nettype none

// Direct-form-I recursive filter section: each input word is one signed sample
// and produces exactly one filtered output word, computed as
// a0*x + a1*x1 + a2*x2 + b1*y1 + b2*y2 + b3*y3 + b4*y4 with signed Q3.20
// coefficients, rounded to nearest, clamped to the output history width and
// optionally halved before it is clamped to the sample width. The section
// accepts one sample per clock cycle while the output word is not stalled. A
// sample is held in the input register, and its result is loaded from there
// into the output register, from which the result word is offered. While the
// output word is stalled, the input takes a new sample only if the input
// register is empty. One sample per cycle is possible because the feedback
// path from the output history, through the b1 to b4 multipliers and the
// adder, back into the history registers holds no register of its own.
// Coefficients and the halve flag are written on the configuration channel
// (index 0 to 6 for a0, a1, a2, b1, b2, b3, b4, index 7 for the halve flag in
// bit 0), which is always ready. Every write clears both histories, so write
// only while no sample is in flight. After reset a0 is 1.0 and all other taps
// are zero.
module recursive_iir_filter_section_top
	import rifs_pkg::*;
#(
	parameter int SAMPLE_WIDTH     = DEF_SAMPLE_WIDTH,
	parameter int COEF_WIDTH       = DEF_COEF_WIDTH,
	parameter int HISTORY_HEADROOM = DEF_HISTORY_HEADROOM,
	localparam int TDATA_W         = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// Sample input stream.
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [TDATA_W-1:0]          s_axis_tdata,   // sample_in
	// Filtered output stream.
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic [TDATA_W-1:0]               m_axis_tdata,   // sample_out
	// Configuration write channel.
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  wire logic [COEF_WIDTH-1:0]       cfg_data
);

	localparam int HW = SAMPLE_WIDTH + HISTORY_HEADROOM;
	localparam logic signed [COEF_WIDTH-1:0] COEF_ONE =
		{{(COEF_INT_BITS-1){1'b0}}, 1'b1, {(COEF_WIDTH-COEF_INT_BITS){1'b0}}};

	logic signed [COEF_WIDTH-1:0]   coef_q   [NUM_COEF];
	logic                           halve_q;
	logic signed [SAMPLE_WIDTH-1:0] x_hist_q [NUM_X_TAPS];
	logic signed [HW-1:0]           y_hist_q [NUM_Y_TAPS];

	logic                           valid_s1;
	logic signed [SAMPLE_WIDTH-1:0] x_s1;
	logic                           out_valid_q;
	logic [SAMPLE_WIDTH-1:0]        out_data_q;

	logic                           advance;
	logic                           cfg_write;
	logic signed [HW-1:0]           y_new;
	logic signed [SAMPLE_WIDTH-1:0] sample;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid;

	// The input stage moves on when the output register is free or drains now.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= COEF_ONE;
			for (int i = 1; i < NUM_COEF; i++) begin
				coef_q[i] <= '0;
			end
			halve_q   <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_COEF_A0:      coef_q[0] <= cfg_data;
				REG_COEF_A1:      coef_q[1] <= cfg_data;
				REG_COEF_A2:      coef_q[2] <= cfg_data;
				REG_COEF_B1:      coef_q[3] <= cfg_data;
				REG_COEF_B2:      coef_q[4] <= cfg_data;
				REG_COEF_B3:      coef_q[5] <= cfg_data;
				REG_COEF_B4:      coef_q[6] <= cfg_data;
				REG_OUTPUT_HALVE: halve_q   <= cfg_data[0];
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			x_s1 <= s_axis_tdata[SAMPLE_WIDTH-1:0];
		end
	end

	// Filter arithmetic for the sample in the input register.
	rifs_mac #(
		.SAMPLE_WIDTH     (SAMPLE_WIDTH),
		.COEF_WIDTH       (COEF_WIDTH),
		.HISTORY_HEADROOM (HISTORY_HEADROOM)
	) u_mac (
		.coef   (coef_q),
		.halve  (halve_q),
		.x      (x_s1),
		.x_hist (x_hist_q),
		.y_hist (y_hist_q),
		.y_new  (y_new),
		.sample (sample)
	);

	// Delay lines shift when a sample leaves the input stage; writes clear them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_X_TAPS; i++) begin
				x_hist_q[i] <= '0;
			end
			for (int i = 0; i < NUM_Y_TAPS; i++) begin
				y_hist_q[i] <= '0;
			end
		end else if (cfg_write) begin
			for (int i = 0; i < NUM_X_TAPS; i++) begin
				x_hist_q[i] <= '0;
			end
			for (int i = 0; i < NUM_Y_TAPS; i++) begin
				y_hist_q[i] <= '0;
			end
		end else if (advance) begin
			x_hist_q[0] <= x_s1;
			for (int i = 1; i < NUM_X_TAPS; i++) begin
				x_hist_q[i] <= x_hist_q[i-1];
			end
			y_hist_q[0] <= y_new;
			for (int i = 1; i < NUM_Y_TAPS; i++) begin
				y_hist_q[i] <= y_hist_q[i-1];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= sample;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TDATA_W'(out_data_q);

endmodule

`default_nettype wire

>>> design/rifs_checker.sv
`default_nettype none

module rifs_checker #(
	parameter int TDATA_WIDTH = 16
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_axis_tvalid,
	input wire logic                   s_axis_tready,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	input wire logic [TDATA_WIDTH-1:0] m_axis_tdata
);

	// A stalled output word stays offered.
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output word withdrawn while stalled");

	// A stalled output word keeps its value.
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	// With the output register empty the section can always take a sample.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with an empty output register");

	// An accepted sample reaches the output register if the sink is ready in the
	// cycle after its acceptance.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
		else $error("accepted sample produced no output word");

endmodule

bind recursive_iir_filter_section_top rifs_checker #(
	.TDATA_WIDTH (TDATA_W)
) u_rifs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> bench/recursive_iir_filter_section_top_test.sv
`timescale 1ns / 1ps

module recursive_iir_filter_section_top_test;
	import rifs_pkg::*;

	localparam int SW       = DEF_SAMPLE_WIDTH;
	localparam int CW       = DEF_COEF_WIDTH;
	localparam int HW       = DEF_SAMPLE_WIDTH + DEF_HISTORY_HEADROOM;
	localparam int FRAC     = DEF_COEF_WIDTH - COEF_INT_BITS;
	localparam int TDATA_W  = ((SW + 7) / 8) * 8;

	localparam int IDLE_PCT       = 22;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 6;
	localparam int RANDOM_ITEMS   = 1300;

	localparam logic [CW-1:0] COEF_ONE  = CW'(1) << FRAC;
	localparam logic [CW-1:0] COEF_HALF = CW'(1) << (FRAC - 1);
	localparam logic [CW-1:0] COEF_MAX  = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] COEF_MIN  = {1'b1, {(CW-1){1'b0}}};

	localparam longint HIST_MAX = (longint'(1) << (HW - 1)) - 1;
	localparam longint HIST_MIN = -(longint'(1) << (HW - 1));
	localparam longint OUT_MAX  = (longint'(1) << (SW - 1)) - 1;
	localparam longint OUT_MIN  = -(longint'(1) << (SW - 1));

	logic                        clk;
	logic                        arst_n;
	logic                        s_axis_tvalid;
	logic                        s_axis_tready;
	logic [TDATA_W-1:0]          s_axis_tdata;   // sample_in
	logic                        m_axis_tvalid;
	logic                        m_axis_tready = 1'b0;
	logic [TDATA_W-1:0]          m_axis_tdata;   // sample_out
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0]  cfg_index;
	logic [CW-1:0]               cfg_data;

	// Predicted filter state and configuration.
	logic signed [CW-1:0] tap_weight [NUM_COEF];
	logic                 halve_en;
	logic signed [SW-1:0] x_hist [NUM_X_TAPS];
	logic signed [HW-1:0] y_hist [NUM_Y_TAPS];

	logic [SW-1:0] expected_out [$];
	logic [SW-1:0] oldest_out;

	bit no_idle;
	int mismatch_count;
	int samples_sent;
	int reg_writes;
	int results_checked;
	int random_sent;
	int idle_cycles;

	recursive_iir_filter_section_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Clear both delay lines, as any register write does.
	function automatic void clear_history();
		for (int i = 0; i < NUM_X_TAPS; i++) x_hist[i] = '0;
		for (int i = 0; i < NUM_Y_TAPS; i++) y_hist[i] = '0;
	endfunction

	function automatic void load_defaults();
		for (int i = 0; i < NUM_COEF; i++) tap_weight[i] = '0;
		tap_weight[REG_COEF_A0] = COEF_ONE;
		halve_en = 1'b0;
		clear_history();
	endfunction

	function automatic void apply_reg(input cfg_reg_t idx, input logic [CW-1:0] d);
		if (idx == REG_OUTPUT_HALVE) begin
			halve_en = d[0];
		end else begin
			tap_weight[idx] = d;
		end
		clear_history();
	endfunction

	// One filter step: weighted sum, round half up, clamp to the history
	// width, update the delay lines, then optionally halve and clamp.
	function automatic logic [SW-1:0] filter_predict(input logic signed [SW-1:0] x);
		longint acc;
		longint y;
		longint o;
		acc = longint'(tap_weight[REG_COEF_A0]) * longint'(x)
			+ longint'(tap_weight[REG_COEF_A1]) * longint'(x_hist[0])
			+ longint'(tap_weight[REG_COEF_A2]) * longint'(x_hist[1])
			+ longint'(tap_weight[REG_COEF_B1]) * longint'(y_hist[0])
			+ longint'(tap_weight[REG_COEF_B2]) * longint'(y_hist[1])
			+ longint'(tap_weight[REG_COEF_B3]) * longint'(y_hist[2])
			+ longint'(tap_weight[REG_COEF_B4]) * longint'(y_hist[3]);
		acc = acc + (longint'(1) << (FRAC - 1));
		y = acc >>> FRAC;
		if (y > HIST_MAX) y = HIST_MAX;
		else if (y < HIST_MIN) y = HIST_MIN;
		for (int i = NUM_Y_TAPS - 1; i > 0; i--) y_hist[i] = y_hist[i-1];
		y_hist[0] = y[HW-1:0];
		for (int i = NUM_X_TAPS - 1; i > 0; i--) x_hist[i] = x_hist[i-1];
		x_hist[0] = x;
		o = halve_en ? (y >>> 1) : y;
		if (o > OUT_MAX) o = OUT_MAX;
		else if (o < OUT_MIN) o = OUT_MIN;
		return o[SW-1:0];
	endfunction

	function automatic logic [CW-1:0] to_coef(input real r);
		int v;
		v = $rtoi(r * (2.0 ** FRAC));
		return v[CW-1:0];
	endfunction

	function automatic logic [SW-1:0] random_sample();
		logic [31:0] rnd;
		rnd = $urandom;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(4))
					0: return {1'b0, {(SW-1){1'b1}}};
					1: return {1'b1, {(SW-1){1'b0}}};
					2: return '0;
					3: return SW'(1);
					default: return '1;
				endcase
			end
			1, 2: return SW'($urandom_range(511)) - SW'(256);
			default: return rnd[SW-1:0];
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Wait until every predicted word has come back and the pipeline is empty.
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_out.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CW-1:0] d);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, d);
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Offer one sample word, with random idle cycles ahead of it.
	task automatic send_sample(input logic [SW-1:0] smp);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= TDATA_W'(smp);
		do @(posedge clk); while (!s_axis_tready);
		expected_out.push_back(filter_predict(smp));
		samples_sent++;
	endtask

	task automatic write_halve(input logic bit_val);
		logic [31:0] rnd;
		rnd = $urandom;
		write_reg(REG_OUTPUT_HALVE, {rnd[CW-1:1], bit_val});
	endtask

	// Reset values give a pass-through filter.
	task automatic test_reset_defaults();
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh0000);
		send_sample(16'sh0001);
		send_sample(16'shffff);
	endtask

	// Half weights put the sum exactly on a tie; ties round upward.
	task automatic test_rounding_ties();
		write_reg(REG_COEF_A0, COEF_HALF);
		send_sample(16'sd1);
		send_sample(-16'sd1);
		send_sample(16'sd3);
		send_sample(-16'sd3);
	endtask

	// Halving floors toward minus infinity.
	task automatic test_output_halving();
		write_halve(1'b1);
		write_reg(REG_COEF_A0, COEF_ONE);
		send_sample(-16'sd3);
		send_sample(16'sd3);
		send_sample(-16'sd1);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
	endtask

	// Extreme weights drive the output into both clamps, then feed back.
	task automatic test_history_saturation();
		write_halve(1'b0);
		write_reg(REG_COEF_A0, COEF_MAX);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		write_halve(1'b1);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		write_reg(REG_COEF_A0, COEF_ONE);
		write_reg(REG_COEF_A1, COEF_MIN);
		write_reg(REG_COEF_B1, COEF_MAX);
		write_reg(REG_COEF_B4, COEF_MIN);
		send_sample(16'sd1000);
		send_sample(16'sd0);
		send_sample(16'sh8000);
		send_sample(16'sd0);
	endtask

	// Phases of filter shapes with random samples; some phases rewrite a
	// register midway, which must clear the histories.
	task automatic test_random_filters();
		logic [CW-1:0] w [NUM_COEF];
		logic          halve;
		logic [31:0]   rnd;
		real           p;
		real           r;
		real           c;
		int            phase_len;
		int            mid_rewrite;
		int            idx;
		while (random_sent < RANDOM_ITEMS) begin
			for (int i = 0; i < NUM_COEF; i++) w[i] = '0;
			p = real'($urandom_range(950)) / 1000.0;
			r = 0.5 + real'($urandom_range(490)) / 1000.0;
			c = real'($urandom_range(2000)) / 1000.0 - 1.0;
			halve = 1'b0;
			case ($urandom_range(6))
				0: begin
					w[REG_COEF_A0] = to_coef(1.0 - p);
					w[REG_COEF_B1] = to_coef(p);
				end
				1: begin
					w[REG_COEF_A0] = to_coef((1.0 + p) / 2.0);
					w[REG_COEF_A1] = to_coef(-(1.0 + p) / 2.0);
					w[REG_COEF_B1] = to_coef(p);
				end
				2: begin
					w[REG_COEF_A0] = to_coef((1.0 - p) ** 4);
					w[REG_COEF_B1] = to_coef(4.0 * p);
					w[REG_COEF_B2] = to_coef(-6.0 * p * p);
					w[REG_COEF_B3] = to_coef(4.0 * p * p * p);
					w[REG_COEF_B4] = to_coef(-(p ** 4));
				end
				3: begin
					w[REG_COEF_A0] = to_coef(1.0 - r);
					w[REG_COEF_A2] = to_coef(r - 1.0);
					w[REG_COEF_B1] = to_coef(2.0 * r * c);
					w[REG_COEF_B2] = to_coef(-r * r);
					halve = 1'b1;
				end
				4: begin
					w[REG_COEF_A0] = COEF_ONE;
					w[REG_COEF_A1] = to_coef(-2.0 * c);
					w[REG_COEF_A2] = COEF_ONE;
					w[REG_COEF_B1] = to_coef(2.0 * r * c);
					w[REG_COEF_B2] = to_coef(-r * r);
					halve = 1'b1;
				end
				5: begin
					for (int i = 0; i < NUM_COEF; i++) begin
						rnd = $urandom;
						w[i] = rnd[CW-1:0];
					end
					halve = 1'($urandom_range(1));
				end
				default: begin
					for (int i = 0; i < NUM_COEF; i++) begin
						case ($urandom_range(3))
							0: w[i] = COEF_MIN;
							1: w[i] = COEF_MAX;
							2: w[i] = COEF_ONE;
							default: w[i] = '0;
						endcase
					end
					halve = 1'($urandom_range(1));
				end
			endcase
			for (int i = 0; i < NUM_COEF; i++) write_reg(cfg_reg_t'(i), w[i]);
			write_halve(halve);

			phase_len = $urandom_range(140, 20);
			mid_rewrite = ($urandom_range(3) == 0) ? $urandom_range(phase_len - 1, 5) : -1;
			for (int n = 0; n < phase_len; n++) begin
				no_idle = (random_sent >= 500) && (random_sent < 800);
				if (n == mid_rewrite) begin
					idx = $urandom_range(NUM_COEF);
					if (idx == NUM_COEF) write_halve(halve_en);
					else write_reg(cfg_reg_t'(idx), tap_weight[idx]);
				end
				send_sample(random_sample());
				random_sent++;
			end
		end
		no_idle = 1'b0;
	endtask

	// Receiver back-pressure.
	always @(negedge clk) begin
		m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
	end

	// Compare each output word with the oldest prediction.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_out.size() == 0) begin
				report_mismatch($sformatf("output word %h with no sample pending",
					m_axis_tdata[SW-1:0]));
			end else begin
				oldest_out = expected_out.pop_front();
				results_checked++;
				if (m_axis_tdata[SW-1:0] !== oldest_out) begin
					report_mismatch($sformatf("sample_out got %h expected %h",
						m_axis_tdata[SW-1:0], oldest_out));
				end
			end
		end
	end

	// Watchdog on cycles in which no word moves on any channel.
	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("watchdog expired with %0d words pending", expected_out.size());
		$display("recursive_iir_filter_section_top regression: fail");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_COEF_A0;
		cfg_data      = '0;
		no_idle       = 1'b0;
		load_defaults();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_rounding_ties();
		test_output_halving();
		test_history_saturation();
		test_random_filters();
		settle();

		$display("covered %0d samples over %0d register writes, %0d output words checked",
			samples_sent, reg_writes, results_checked);
		$display("filter shapes: pass-through, ties, halving, clamps, low/high/band and random taps");
		if (mismatch_count == 0) begin
			$display("recursive_iir_filter_section_top regression: pass");
		end else begin
			$display("recursive_iir_filter_section_top regression: fail");
		end
		$finish;
	end

endmodule

>>> filelist.f
design/rifs_pkg.sv
design/rifs_mac.sv
design/recursive_iir_filter_section_top.sv
design/rifs_checker.sv
bench/recursive_iir_filter_section_top_test.sv
